// ===== design/assert_macros.svh =====
// Assertion macros shared by the accumulator execute core RTL.
// Bodies compile away when SYNTHESIS is defined; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ACE_ASSERT_ALWAYS(name, expr, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) else $error(msg);
`define ACE_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ACE_ASSERT_ALWAYS(name, expr, msg)
`define ACE_ASSERT_NEXT(name, ante, cons, msg)
`endif
`endif

// ===== design/ace_pkg.sv =====
// Shared types and constants for the accumulator execute core.
// No dependencies; used by every module of the core except ace_ram.
package ace_pkg;

    localparam int ADDR_BITS_DEF = 16;
    localparam int QDEPTH = 2;
    localparam int RESULT_BITS = 112;

    localparam logic [7:0] OPC_HALT  = 8'h00;
    localparam logic [7:0] OPC_LOAD  = 8'h01;
    localparam logic [7:0] OPC_STORE = 8'h02;
    localparam logic [7:0] OPC_ADD   = 8'h03;
    localparam logic [7:0] OPC_SUB   = 8'h04;
    localparam logic [7:0] OPC_CMP   = 8'h05;
    localparam logic [7:0] OPC_JZ    = 8'h06;
    localparam logic [7:0] OPC_JNZ   = 8'h07;
    localparam logic [7:0] OPC_JMP   = 8'h08;
    localparam logic [7:0] OPC_SWAP  = 8'h09;
    localparam logic [7:0] OPC_INC   = 8'h0A;

    typedef enum logic [3:0] {
        OP_HALT,
        OP_LOAD,
        OP_STORE,
        OP_ADD,
        OP_SUB,
        OP_CMP,
        OP_JZ,
        OP_JNZ,
        OP_JMP,
        OP_SWAP,
        OP_INC,
        OP_BAD,
        OP_PRELOAD
    } op_t;

    typedef struct packed {
        logic [7:0]  high;
        logic [15:0] total;
    } cell_t;

    typedef struct packed {
        op_t         op;
        logic [15:0] operand;
        logic [15:0] load_value;
    } qentry_t;

    typedef struct packed {
        logic    valid;
        qentry_t entry;
    } qhead_t;

    typedef struct packed {
        logic clear_busy;
        logic running;
    } status_t;

    typedef struct packed {
        logic [5:0]  pad;
        logic [15:0] counted_ops;
        logic        bad_opcode;
        logic        is_running;
        logic [7:0]  r_high;
        logic [15:0] r_total;
        logic [7:0]  b_high;
        logic [15:0] b_total;
        logic [7:0]  a_high;
        logic [15:0] a_total;
        logic [15:0] next_pc;
    } result_t;

endpackage

// ===== design/accumulator_cpu_execute_core.sv =====
// Accumulator machine execute core: one instruction or store preload per transaction.
// Each transaction passes the input queue, the execute register and the output register.
// Throughput: one transaction per cycle while the output is not stalled; a load reads the
// synchronous data store as its item enters the execute register, with a forwarding
// register for a store made in that cycle. Reset: synchronous; afterwards a clearing pass
// zeroes all 2^ADDR_BITS store words, during which no input transaction is accepted.
`include "assert_macros.svh"
module accumulator_cpu_execute_core #(
    parameter int ADDR_BITS = ace_pkg::ADDR_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // opcode[7:0], operand[23:8], load_value[39:24]
    input  logic        s_tuser,   // mode
    output logic        m_tvalid,
    input  logic        m_tready,
    // next_pc[15:0], a_total[31:16], a_high[39:32], b_total[55:40], b_high[63:56],
    // r_total[79:64], r_high[87:80], is_running[88], bad_opcode[89],
    // counted_ops[105:90], zero fill[111:106]
    output logic [ace_pkg::RESULT_BITS-1:0] m_tdata
);

    ace_pkg::qhead_t  head;
    ace_pkg::status_t status;
    logic             pop;
    ace_pkg::result_t m_view;

    ace_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .hold     (status.clear_busy),
        .pop      (pop),
        .head     (head)
    );

    ace_back #(
        .ADDR_BITS(ADDR_BITS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .status   (status)
    );

    assign m_view = m_tdata;

    `ACE_ASSERT_ALWAYS(a_no_accept_in_clear, !(status.clear_busy && s_tready),
        "input accepted during store clear")
    `ACE_ASSERT_ALWAYS(a_no_result_in_clear, !(status.clear_busy && m_tvalid),
        "result during store clear")
    `ACE_ASSERT_NEXT(a_halt_sticky, !status.running, !status.running,
        "machine restarted after halt")
    `ACE_ASSERT_ALWAYS(a_bad_halts,
        !(m_tvalid && m_view.bad_opcode) || !m_view.is_running,
        "bad opcode left machine running")

endmodule

// ===== design/ace_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ace_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/ace_front.sv =====
// Front end: accepts input transactions, decodes the opcode and queues the item.
// Depends on ace_pkg.
module ace_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [39:0]         s_tdata,  // opcode[7:0], operand[23:8], load_value[39:24]
    input  logic                s_tuser,  // mode
    input  logic                hold,
    input  logic                pop,
    output ace_pkg::qhead_t     head
);

    localparam int PTR_BITS = (ace_pkg::QDEPTH > 1) ? $clog2(ace_pkg::QDEPTH) : 1;
    localparam int CNT_BITS = $clog2(ace_pkg::QDEPTH + 1);

    ace_pkg::qentry_t      entry_reg [ace_pkg::QDEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg;
    logic [PTR_BITS-1:0]   rd_ptr_reg;
    logic [CNT_BITS-1:0]   count_reg;
    logic [CNT_BITS-1:0]   count_next;
    ace_pkg::qentry_t      decoded;
    logic                  push;
    logic                  do_pop;

    always_comb begin
        decoded.operand = s_tdata[23:8];
        decoded.load_value = s_tdata[39:24];
        if (s_tuser) begin
            decoded.op = ace_pkg::OP_PRELOAD;
        end else begin
            case (s_tdata[7:0])
                ace_pkg::OPC_HALT:  decoded.op = ace_pkg::OP_HALT;
                ace_pkg::OPC_LOAD:  decoded.op = ace_pkg::OP_LOAD;
                ace_pkg::OPC_STORE: decoded.op = ace_pkg::OP_STORE;
                ace_pkg::OPC_ADD:   decoded.op = ace_pkg::OP_ADD;
                ace_pkg::OPC_SUB:   decoded.op = ace_pkg::OP_SUB;
                ace_pkg::OPC_CMP:   decoded.op = ace_pkg::OP_CMP;
                ace_pkg::OPC_JZ:    decoded.op = ace_pkg::OP_JZ;
                ace_pkg::OPC_JNZ:   decoded.op = ace_pkg::OP_JNZ;
                ace_pkg::OPC_JMP:   decoded.op = ace_pkg::OP_JMP;
                ace_pkg::OPC_SWAP:  decoded.op = ace_pkg::OP_SWAP;
                ace_pkg::OPC_INC:   decoded.op = ace_pkg::OP_INC;
                default:            decoded.op = ace_pkg::OP_BAD;
            endcase
        end
    end

    assign s_tready = (count_reg != CNT_BITS'(ace_pkg::QDEPTH)) && !hold;
    assign push = s_tvalid && s_tready;
    assign do_pop = pop && (count_reg != '0);

    always_comb begin
        count_next = count_reg;
        if (push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= decoded;
        end
    end

    assign head.valid = (count_reg != '0);
    assign head.entry = entry_reg[rd_ptr_reg];

endmodule

// ===== design/ace_back.sv =====
// Back end: data store, machine state and instruction execution with store forwarding.
// Depends on ace_pkg and ace_ram.
module ace_back #(
    parameter int ADDR_BITS = ace_pkg::ADDR_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  ace_pkg::qhead_t                head,
    output logic                           pop,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [ace_pkg::RESULT_BITS-1:0] m_tdata,
    output ace_pkg::status_t               status
);

    localparam int DEPTH = 1 << ADDR_BITS;

    logic                 clr_busy_reg;
    logic [ADDR_BITS-1:0] clr_addr_reg;

    logic                 ex_valid_reg;
    ace_pkg::qentry_t     ex_reg;
    logic                 fwd_valid_reg;
    ace_pkg::cell_t       fwd_data_reg;

    ace_pkg::cell_t       a_reg, a_next;
    ace_pkg::cell_t       b_reg, b_next;
    ace_pkg::cell_t       r_reg, r_next;
    logic [15:0]          pc_reg, pc_next;
    logic                 run_reg, run_next;
    logic [15:0]          tally_reg, tally_next;
    logic                 bad;

    logic                 out_valid_reg;
    ace_pkg::result_t     out_reg;
    ace_pkg::result_t     res_next;

    logic                 out_free;
    logic                 ex_fire;
    logic                 st_we;
    logic [ADDR_BITS-1:0] st_waddr;
    ace_pkg::cell_t       st_wdata;
    logic [ADDR_BITS-1:0] head_addr;
    ace_pkg::cell_t       ram_rdata;
    ace_pkg::cell_t       mem_data;
    logic                 ram_we;
    logic [ADDR_BITS-1:0] ram_waddr;
    ace_pkg::cell_t       ram_wdata;

    assign out_free = !out_valid_reg || m_tready;
    assign ex_fire = ex_valid_reg && out_free;
    assign pop = head.valid && (!ex_valid_reg || ex_fire) && !clr_busy_reg;
    assign head_addr = head.entry.operand[ADDR_BITS-1:0];
    assign mem_data = fwd_valid_reg ? fwd_data_reg : ram_rdata;

    always_comb begin
        a_next = a_reg;
        b_next = b_reg;
        r_next = r_reg;
        pc_next = pc_reg;
        run_next = run_reg;
        tally_next = tally_reg;
        bad = 1'b0;
        st_we = 1'b0;
        st_waddr = ex_reg.operand[ADDR_BITS-1:0];
        st_wdata = a_reg;
        if (run_reg) begin
            case (ex_reg.op)
                ace_pkg::OP_PRELOAD: begin
                    st_we = 1'b1;
                    st_wdata.total = ex_reg.load_value;
                    st_wdata.high = ex_reg.load_value[15:8];
                end
                ace_pkg::OP_HALT: begin
                    run_next = 1'b0;
                    pc_next = pc_reg + 16'd1;
                end
                ace_pkg::OP_LOAD: begin
                    b_next = a_reg;
                    a_next = mem_data;
                    pc_next = pc_reg + 16'd3;
                    tally_next = tally_reg + 16'd1;
                end
                ace_pkg::OP_STORE: begin
                    r_next = a_reg;
                    st_we = 1'b1;
                    pc_next = pc_reg + 16'd3;
                    tally_next = tally_reg + 16'd1;
                end
                ace_pkg::OP_ADD: begin
                    r_next.total = a_reg.total + b_reg.total;
                    r_next.high = a_reg.high + b_reg.high;
                    pc_next = pc_reg + 16'd1;
                    tally_next = tally_reg + 16'd1;
                end
                ace_pkg::OP_SUB: begin
                    r_next.total = a_reg.total - b_reg.total;
                    r_next.high = a_reg.high - b_reg.high;
                    pc_next = pc_reg + 16'd1;
                    tally_next = tally_reg + 16'd1;
                end
                ace_pkg::OP_CMP: begin
                    pc_next = pc_reg + 16'd3;
                end
                ace_pkg::OP_JZ: begin
                    pc_next = (a_reg.total == 16'd0) ? ex_reg.operand : pc_reg + 16'd3;
                end
                ace_pkg::OP_JNZ: begin
                    pc_next = (a_reg.total != 16'd0) ? ex_reg.operand : pc_reg + 16'd3;
                end
                ace_pkg::OP_JMP: begin
                    pc_next = ex_reg.operand;
                end
                ace_pkg::OP_SWAP: begin
                    a_next = b_reg;
                    b_next = a_reg;
                    pc_next = pc_reg + 16'd1;
                end
                ace_pkg::OP_INC: begin
                    a_next.total = a_reg.total + 16'd1;
                    pc_next = pc_reg + 16'd1;
                end
                default: begin
                    run_next = 1'b0;
                    bad = 1'b1;
                end
            endcase
        end
    end

    always_comb begin
        res_next.pad = '0;
        res_next.counted_ops = tally_next;
        res_next.bad_opcode = bad;
        res_next.is_running = run_next;
        res_next.r_high = r_next.high;
        res_next.r_total = r_next.total;
        res_next.b_high = b_next.high;
        res_next.b_total = b_next.total;
        res_next.a_high = a_next.high;
        res_next.a_total = a_next.total;
        res_next.next_pc = pc_next;
    end

    assign ram_we = clr_busy_reg || (ex_fire && st_we);
    assign ram_waddr = clr_busy_reg ? clr_addr_reg : st_waddr;
    assign ram_wdata = clr_busy_reg ? '0 : st_wdata;

    ace_ram #(
        .WIDTH($bits(ace_pkg::cell_t)),
        .DEPTH(DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (pop),
        .raddr (head_addr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
            ex_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            a_reg <= '0;
            b_reg <= '0;
            r_reg <= '0;
            pc_reg <= '0;
            run_reg <= 1'b1;
            tally_reg <= '0;
        end else begin
            if (clr_busy_reg) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == '1) begin
                    clr_busy_reg <= 1'b0;
                end
            end
            if (pop) begin
                ex_valid_reg <= 1'b1;
            end else if (ex_fire) begin
                ex_valid_reg <= 1'b0;
            end
            if (ex_fire) begin
                out_valid_reg <= 1'b1;
                a_reg <= a_next;
                b_reg <= b_next;
                r_reg <= r_next;
                pc_reg <= pc_next;
                run_reg <= run_next;
                tally_reg <= tally_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            ex_reg <= head.entry;
            fwd_valid_reg <= ex_fire && st_we && (st_waddr == head_addr);
            fwd_data_reg <= st_wdata;
        end
        if (ex_fire) begin
            out_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = out_reg;
    assign status.clear_busy = clr_busy_reg;
    assign status.running = run_reg;

endmodule
